// ===== src/run_skip_dump_frame_decoder_defines.svh =====
// Assertion macros shared by the run/skip/dump frame decoder RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef RUN_SKIP_DUMP_FRAME_DECODER_DEFINES_SVH
`define RUN_SKIP_DUMP_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsd check failed");

`endif

// ===== src/rsd_pkg.sv =====
// Shared types, codes and constants of the run/skip/dump frame decoder.
// Depends on nothing; used by every module of the block.
`default_nettype none

package rsd_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [15:0] FRAME_BYTES_RST = 16'd64000;
	localparam logic [23:0] STOP_TAIL       = 24'h800000;
	localparam logic [7:0]  LONG_OP         = 8'h80;
	localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;

	localparam logic REQ_DATA  = 1'b0;
	localparam logic REQ_EMPTY = 1'b1;

	localparam logic RK_WRITE  = 1'b0;
	localparam logic RK_STATUS = 1'b1;

	typedef enum logic [3:0] {
		PH_TYPE_LO,
		PH_TYPE_HI,
		PH_RAW,
		PH_IGNORE,
		PH_OP,
		PH_DUMP,
		PH_RUN_CNT,
		PH_RUN_VAL,
		PH_LONG_LO,
		PH_LONG_HI,
		PH_LRUN_VAL
	} phase_t;

	typedef enum logic [1:0] {
		BK_RAW,
		BK_RSD,
		BK_OTHER
	} body_kind_t;

	// Opcode class of a byte seen at an opcode position.
	typedef enum logic [1:0] {
		BC_RUN,
		BC_SHORT_DUMP,
		BC_LONG,
		BC_SKIP
	} byte_class_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_STOP,
		ST_BAD_TYPE,
		ST_SIZE,
		ST_OVERRUN
	} status_t;

	typedef struct packed {
		logic        empty_req;
		logic        last;
		byte_class_t cls;
		logic [7:0]  data;
	} token_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] wr_offset;
		logic [13:0] wr_length;
		logic [7:0]  wr_value;
		status_t     status;
	} result_t;

endpackage

`default_nettype wire

// ===== src/rsd_fifo.sv =====
// Short token queue between the front classifier and the back executor.
// Depends on rsd_pkg (token_t) and the assertion macro header.
`default_nettype none
`include "run_skip_dump_frame_decoder_defines.svh"

module rsd_fifo #(
	parameter int DEPTH = rsd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  rsd_pkg::token_t      push_tok,
	output logic                 full,
	input  wire logic            pop,
	output rsd_pkg::token_t      pop_tok,
	output logic                 not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rsd_pkg::token_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_tok   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	`RSD_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`RSD_ASSERT_NEXT(a_pop_drains, clk, arst_n, do_pop && !do_push, cnt_q == $past(cnt_q) - CNT_W'(1))
	`RSD_ASSERT_NEXT(a_push_fills, clk, arst_n, do_push && !do_pop, cnt_q == $past(cnt_q) + CNT_W'(1))

endmodule

`default_nettype wire

// ===== src/rsd_front.sv =====
// Front end: accepts input words and tags each byte with its opcode class.
// Depends on rsd_pkg (token_t, byte_class_t, request codes).
`default_nettype none

module rsd_front (
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [7:0]      s_tdata,
	input  wire logic            s_tuser,
	input  wire logic            s_tlast,
	input  wire logic            q_full,
	output logic                 q_push,
	output rsd_pkg::token_t      q_tok
);

	rsd_pkg::byte_class_t cls;

	always_comb begin
		if (s_tdata == '0) begin
			cls = rsd_pkg::BC_RUN;
		end else if (!s_tdata[7]) begin
			cls = rsd_pkg::BC_SHORT_DUMP;
		end else if (s_tdata == rsd_pkg::LONG_OP) begin
			cls = rsd_pkg::BC_LONG;
		end else begin
			cls = rsd_pkg::BC_SKIP;
		end
	end

	assign s_tready        = !q_full;
	assign q_push          = s_tvalid && !q_full;
	assign q_tok.empty_req = (s_tuser == rsd_pkg::REQ_EMPTY);
	assign q_tok.last      = s_tlast;
	assign q_tok.cls       = cls;
	assign q_tok.data      = s_tdata;

endmodule

`default_nettype wire

// ===== src/rsd_back.sv =====
// Back end: record state machine, frame offset tracking, end-of-record checks
// and the output register. Depends on rsd_pkg and the assertion macro header.
`default_nettype none
`include "run_skip_dump_frame_decoder_defines.svh"

module rsd_back #(
	parameter int OFFSET_BITS = rsd_pkg::OFFSET_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [15:0]     cfg_wdata,
	input  wire logic            tok_valid,
	input  rsd_pkg::token_t      tok,
	output logic                 tok_pop,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output rsd_pkg::result_t     res
);

	localparam int OFF_W = OFFSET_BITS + 1;
	localparam int SUM_W = ((OFF_W > 16) ? OFF_W : 16) + 1;
	localparam logic [SUM_W-1:0] OFF_MAX = {{(SUM_W - OFF_W){1'b0}}, {OFF_W{1'b1}}};

	rsd_pkg::phase_t     phase_q, phase_d;
	rsd_pkg::body_kind_t kind_q, kind_d;
	logic [OFF_W-1:0]    off_q, off_d;
	logic [13:0]         rem_q, rem_d;
	logic [7:0]          lo_q, lo_d;
	logic [23:0]         tail_q, tail_d;
	logic [16:0]         cnt_q, cnt_d;
	logic                stopped_q, stopped_d;
	logic                ovr_q, ovr_d;
	logic [15:0]         frame_q;
	logic                valid_q;
	rsd_pkg::result_t    out_q, res_d;

	logic                in_body, write_try, wr_fire, fits, produce, clear;
	logic [14:0]         adv_n;
	logic [SUM_W-1:0]    off_ext, sum;
	rsd_pkg::status_t    st;

	assign tok_pop = tok_valid && (!valid_q || res_ready);
	assign clear   = tok.empty_req || tok.last;
	assign in_body = (phase_q != rsd_pkg::PH_TYPE_LO) && (phase_q != rsd_pkg::PH_TYPE_HI);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			rsd_pkg::PH_TYPE_LO: phase_d = rsd_pkg::PH_TYPE_HI;
			rsd_pkg::PH_TYPE_HI: begin
				if ({tok.data, lo_q} == 16'd0) begin
					phase_d = rsd_pkg::PH_RAW;
				end else if ({tok.data, lo_q} == 16'd1) begin
					phase_d = rsd_pkg::PH_OP;
				end else begin
					phase_d = rsd_pkg::PH_IGNORE;
				end
			end
			rsd_pkg::PH_OP: begin
				if (!stopped_q) begin
					case (tok.cls)
						rsd_pkg::BC_SHORT_DUMP: phase_d = rsd_pkg::PH_DUMP;
						rsd_pkg::BC_RUN:        phase_d = rsd_pkg::PH_RUN_CNT;
						rsd_pkg::BC_LONG:       phase_d = rsd_pkg::PH_LONG_LO;
						default:                phase_d = rsd_pkg::PH_OP;
					endcase
				end
			end
			rsd_pkg::PH_DUMP:     phase_d = (rem_q <= 14'd1) ? rsd_pkg::PH_OP : rsd_pkg::PH_DUMP;
			rsd_pkg::PH_RUN_CNT:  phase_d = rsd_pkg::PH_RUN_VAL;
			rsd_pkg::PH_RUN_VAL:  phase_d = rsd_pkg::PH_OP;
			rsd_pkg::PH_LRUN_VAL: phase_d = rsd_pkg::PH_OP;
			rsd_pkg::PH_LONG_LO:  phase_d = rsd_pkg::PH_LONG_HI;
			rsd_pkg::PH_LONG_HI: begin
				if (!tok.data[7]) begin
					phase_d = rsd_pkg::PH_OP;
				end else if (!tok.data[6]) begin
					phase_d = ({tok.data[5:0], lo_q} != 14'd0) ? rsd_pkg::PH_DUMP : rsd_pkg::PH_OP;
				end else begin
					phase_d = rsd_pkg::PH_LRUN_VAL;
				end
			end
			default: phase_d = phase_q;
		endcase
		if (clear) begin
			phase_d = rsd_pkg::PH_TYPE_LO;
		end
	end

	// Datapath actions and result.
	always_comb begin
		kind_d    = kind_q;
		rem_d     = rem_q;
		lo_d      = lo_q;
		stopped_d = stopped_q;
		adv_n     = '0;
		write_try = 1'b0;
		if (!tok.empty_req) begin
			case (phase_q)
				rsd_pkg::PH_TYPE_LO: lo_d = tok.data;
				rsd_pkg::PH_TYPE_HI: begin
					lo_d = '0;
					if ({tok.data, lo_q} == 16'd0) begin
						kind_d = rsd_pkg::BK_RAW;
					end else if ({tok.data, lo_q} == 16'd1) begin
						kind_d = rsd_pkg::BK_RSD;
					end else begin
						kind_d = rsd_pkg::BK_OTHER;
					end
				end
				rsd_pkg::PH_RAW: begin
					write_try = 1'b1;
					adv_n     = 15'd1;
				end
				rsd_pkg::PH_OP: begin
					if (!stopped_q) begin
						case (tok.cls)
							rsd_pkg::BC_SHORT_DUMP: rem_d = {6'd0, tok.data};
							rsd_pkg::BC_SKIP:       adv_n = {8'd0, tok.data[6:0]};
							default:                adv_n = '0;
						endcase
					end
				end
				rsd_pkg::PH_DUMP: begin
					write_try = 1'b1;
					adv_n     = 15'd1;
					rem_d     = (rem_q == '0) ? '0 : rem_q - 14'd1;
				end
				rsd_pkg::PH_RUN_CNT: rem_d = {6'd0, tok.data};
				rsd_pkg::PH_RUN_VAL, rsd_pkg::PH_LRUN_VAL: begin
					write_try = 1'b1;
					adv_n     = {1'b0, rem_q};
					rem_d     = '0;
				end
				rsd_pkg::PH_LONG_LO: lo_d = tok.data;
				rsd_pkg::PH_LONG_HI: begin
					if (!tok.data[7]) begin
						if ({tok.data, lo_q} == 16'd0) begin
							stopped_d = 1'b1;
						end else begin
							adv_n = {tok.data[6:0], lo_q};
						end
					end else begin
						rem_d = {tok.data[5:0], lo_q};
					end
				end
				default: adv_n = '0;
			endcase
		end

		off_ext = SUM_W'(off_q);
		sum     = off_ext + SUM_W'(adv_n);
		fits    = (sum <= SUM_W'(frame_q));
		wr_fire = write_try && (adv_n != '0) && fits;
		ovr_d   = ovr_q || (write_try && (adv_n != '0) && !fits);
		off_d   = (sum > OFF_MAX) ? OFF_MAX[OFF_W-1:0] : sum[OFF_W-1:0];

		cnt_d  = cnt_q;
		tail_d = tail_q;
		if (in_body) begin
			cnt_d  = (cnt_q == rsd_pkg::COUNT_MAX) ? cnt_q : cnt_q + 17'd1;
			tail_d = {tail_q[15:0], tok.data};
		end

		st = rsd_pkg::ST_OK;
		if (tok.empty_req) begin
			st = rsd_pkg::ST_OK;
		end else if (phase_q == rsd_pkg::PH_TYPE_LO) begin
			st = rsd_pkg::ST_SIZE;
		end else if (phase_q == rsd_pkg::PH_TYPE_HI) begin
			st = rsd_pkg::ST_OK;
		end else begin
			case (kind_q)
				rsd_pkg::BK_RAW: begin
					if (cnt_d != {1'b0, frame_q}) begin
						st = rsd_pkg::ST_SIZE;
					end else begin
						st = ovr_d ? rsd_pkg::ST_OVERRUN : rsd_pkg::ST_OK;
					end
				end
				rsd_pkg::BK_RSD: begin
					if ((cnt_d < 17'd3) || (tail_d != rsd_pkg::STOP_TAIL)) begin
						st = rsd_pkg::ST_BAD_STOP;
					end else begin
						st = ovr_d ? rsd_pkg::ST_OVERRUN : rsd_pkg::ST_OK;
					end
				end
				default: st = rsd_pkg::ST_BAD_TYPE;
			endcase
		end

		produce         = clear || wr_fire;
		res_d.kind      = clear ? rsd_pkg::RK_STATUS : rsd_pkg::RK_WRITE;
		res_d.wr_offset = wr_fire ? off_ext[15:0] : '0;
		res_d.wr_length = wr_fire ? adv_n[13:0] : '0;
		res_d.wr_value  = wr_fire ? tok.data : '0;
		res_d.status    = clear ? st : rsd_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= rsd_pkg::FRAME_BYTES_RST;
			phase_q   <= rsd_pkg::PH_TYPE_LO;
			kind_q    <= rsd_pkg::BK_RAW;
			off_q     <= '0;
			rem_q     <= '0;
			lo_q      <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
			ovr_q     <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_q <= cfg_wdata;
			end
			if (tok_pop) begin
				phase_q <= phase_d;
				if (clear) begin
					kind_q    <= rsd_pkg::BK_RAW;
					off_q     <= '0;
					rem_q     <= '0;
					lo_q      <= '0;
					tail_q    <= '0;
					cnt_q     <= '0;
					stopped_q <= 1'b0;
					ovr_q     <= 1'b0;
				end else begin
					kind_q    <= kind_d;
					off_q     <= off_d;
					rem_q     <= rem_d;
					lo_q      <= lo_d;
					tail_q    <= tail_d;
					cnt_q     <= cnt_d;
					stopped_q <= stopped_d;
					ovr_q     <= ovr_d;
				end
			end
			if (tok_pop && produce) begin
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop && produce) begin
			out_q <= res_d;
		end
	end

	assign res_valid = valid_q;
	assign res       = out_q;

	`RSD_ASSERT_IMPL(a_write_clean, clk, arst_n, valid_q && (out_q.kind == rsd_pkg::RK_WRITE), (out_q.status == rsd_pkg::ST_OK) && (out_q.wr_length != '0))
	`RSD_ASSERT_IMPL(a_fresh_record, clk, arst_n, phase_q == rsd_pkg::PH_TYPE_LO, (cnt_q == '0) && !ovr_q && !stopped_q && (off_q == '0))
	`RSD_ASSERT_NEXT(a_stop_sticky, clk, arst_n, stopped_q && !(tok_pop && clear), stopped_q)

endmodule

`default_nettype wire

// ===== src/run_skip_dump_frame_decoder.sv =====
// Top level of the run/skip/dump frame decoder: front classifier, token queue,
// back executor. Depends on rsd_pkg, rsd_front, rsd_fifo and rsd_back.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  tdata = data_byte, tuser = req_type, tlast = last_byte
//   m_*       out        m_tvalid/m_tready  tdata = offset/length/value/status, tuser = result_kind
//   cfg_*     in         cfg_we             cfg_wdata = frame_bytes
//
// Throughput: one word per cycle in and out while the queue is not full and the
// output is ready; the back end's single add-and-compare on the frame offset sets
// the pace. A word reaches a valid result through the queue, then the output
// register.
// Reset: arst_n clears the record state and sets frame_bytes to 64000.
// Stalls: the queue absorbs output back-pressure; s_tready drops only when the
// queue is full, and the result register keeps taking words while it drains.
`default_nettype none

module run_skip_dump_frame_decoder #(
	parameter int OFFSET_BITS = rsd_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = rsd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// frame_bytes register write
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	// record bytes
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] req_type
	input  wire logic        s_tlast,   // last_byte
	// frame writes and end-of-record status
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [15:0] write_offset, [29:16] write_length,
	                                    // [37:30] write_value, [40:38] status, rest zero
	output logic             m_tuser    // [0] result_kind
);

	rsd_pkg::token_t  push_tok, pop_tok;
	rsd_pkg::result_t res;
	logic             q_full, q_push, q_pop, q_not_empty;

	// Tag each accepted byte with its opcode class.
	rsd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_tok    (push_tok)
	);

	// Hold classified words until the back end can take them.
	rsd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_tok  (push_tok),
		.full      (q_full),
		.pop       (q_pop),
		.pop_tok   (pop_tok),
		.not_empty (q_not_empty)
	);

	// Advance the record state and emit writes and status.
	rsd_back #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.tok_valid (q_not_empty),
		.tok       (pop_tok),
		.tok_pop   (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result fields, lowest field first, zero-filled to six bytes.
	assign m_tdata = {7'd0, res.status, res.wr_value, res.wr_length, res.wr_offset};
	assign m_tuser = res.kind;

endmodule

`default_nettype wire

// ===== test/rsd_test_pkg.sv =====
// Record encoding codes shared by the frame decoder test bench files.
// Depends on nothing; imported by the scoreboard and the test top.
`timescale 1ns / 1ps

package rsd_test_pkg;

	// body type words
	localparam logic [15:0] TYPE_RAW = 16'h0000;
	localparam logic [15:0] TYPE_RSD = 16'h0001;

	// opcode byte that starts a short run (count, value follow)
	localparam logic [7:0] RUN_OP = 8'h00;

	// long-op words: below LONG_DUMP_BASE a skip, from it a dump, from LONG_RUN_BASE a run
	localparam logic [15:0] STOP_WORD      = 16'h0000;
	localparam logic [15:0] LONG_DUMP_BASE = 16'h8000;
	localparam logic [15:0] LONG_RUN_BASE  = 16'hC000;

endpackage

// ===== test/rsd_scoreboard.sv =====
// Scoreboard of the run/skip/dump frame decoder: follows frame_bytes writes,
// predicts the result word, if any, of every accepted record word and compares in order.
// Depends on rsd_pkg and rsd_test_pkg.
`timescale 1ns / 1ps

module rsd_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tuser,
	output int          outstanding,
	output int          failures
);
	import rsd_pkg::*;
	import rsd_test_pkg::*;

	localparam int OFF_MAX = (1 << (OFFSET_BITS_DEF + 1)) - 1;

	logic [15:0]              frame_bytes;
	phase_t                   phase;
	body_kind_t               body_kind;
	logic [OFFSET_BITS_DEF:0] frame_offset;
	logic [14:0]              op_left;
	logic [7:0]               word_lo;
	logic [23:0]              tail;
	logic [16:0]              body_count;
	logic                     stopped;
	logic                     overrun_seen;

	result_t awaited_results[$];
	int      fail_n;

	function automatic void restart_record();
		phase        = PH_TYPE_LO;
		body_kind    = BK_RAW;
		frame_offset = '0;
		op_left      = '0;
		word_lo      = '0;
		tail         = '0;
		body_count   = '0;
		stopped      = 1'b0;
		overrun_seen = 1'b0;
	endfunction

	// saturate rather than wrap
	function automatic void move_offset(input int n);
		int s;
		s = int'(frame_offset) + n;
		frame_offset = (s > OFF_MAX) ? OFF_MAX : s;
	endfunction

	// a write that would end past the frame is dropped whole and flagged
	function automatic bit try_write(input int len, input logic [7:0] val, inout result_t w);
		bit ok;
		ok = 1'b0;
		if (len != 0) begin
			if (int'(frame_offset) + len > int'(frame_bytes)) begin
				overrun_seen = 1'b1;
			end else begin
				w.kind      = RK_WRITE;
				w.wr_offset = frame_offset[15:0];
				w.wr_length = len[13:0];
				w.wr_value  = val;
				w.status    = ST_OK;
				ok          = 1'b1;
			end
		end
		move_offset(len);
		return ok;
	endfunction

	function automatic bit decode_word(input logic req, input logic [7:0] b, input logic last,
		output result_t r);
		logic [15:0] word;
		result_t     w;
		bit          have_w;
		status_t     st;
		have_w = 1'b0;
		w      = '0;
		st     = ST_OK;
		r      = '0;
		if (req == REQ_EMPTY) begin
			restart_record();
			r.kind   = RK_STATUS;
			r.status = ST_OK;
			return 1'b1;
		end
		case (phase)
		PH_TYPE_LO: begin
			word_lo = b;
			phase   = PH_TYPE_HI;
			if (last) st = ST_SIZE;
		end
		PH_TYPE_HI: begin
			word      = {b, word_lo};
			body_kind = (word == TYPE_RAW) ? BK_RAW : ((word == TYPE_RSD) ? BK_RSD : BK_OTHER);
			phase     = (word == TYPE_RAW) ? PH_RAW : ((word == TYPE_RSD) ? PH_OP : PH_IGNORE);
			word_lo   = '0;
		end
		default: begin
			if (body_count != COUNT_MAX) body_count++;
			tail = {tail[15:0], b};
			case (phase)
			PH_RAW: have_w = try_write(1, b, w);
			PH_OP: begin
				if (!stopped) begin
					if (b == RUN_OP) begin
						phase = PH_RUN_CNT;
					end else if (b == LONG_OP) begin
						phase = PH_LONG_LO;
					end else if (b < LONG_OP) begin
						op_left = b;
						phase   = PH_DUMP;
					end else begin
						move_offset(b - LONG_OP);
					end
				end
			end
			PH_DUMP: begin
				have_w = try_write(1, b, w);
				if (op_left != 0) op_left--;
				if (op_left == 0) phase = PH_OP;
			end
			PH_RUN_CNT: begin
				op_left = b;
				phase   = PH_RUN_VAL;
			end
			PH_RUN_VAL, PH_LRUN_VAL: begin
				have_w  = try_write(op_left, b, w);
				op_left = '0;
				phase   = PH_OP;
			end
			PH_LONG_LO: begin
				word_lo = b;
				phase   = PH_LONG_HI;
			end
			PH_LONG_HI: begin
				word  = {b, word_lo};
				phase = PH_OP;
				if (word == STOP_WORD) begin
					stopped = 1'b1;
				end else if (word < LONG_DUMP_BASE) begin
					move_offset(word);
				end else if (word < LONG_RUN_BASE) begin
					op_left = word - LONG_DUMP_BASE;
					if (op_left != 0) phase = PH_DUMP;
				end else begin
					op_left = word - LONG_RUN_BASE;
					phase   = PH_LRUN_VAL;
				end
			end
			default: ;
			endcase
			if (last) begin
				case (body_kind)
				BK_RAW: st = (body_count != {1'b0, frame_bytes}) ? ST_SIZE :
					(overrun_seen ? ST_OVERRUN : ST_OK);
				BK_RSD: st = (body_count < 3 || tail != STOP_TAIL) ? ST_BAD_STOP :
					(overrun_seen ? ST_OVERRUN : ST_OK);
				default: st = ST_BAD_TYPE;
				endcase
			end
		end
		endcase
		if (last) begin
			restart_record();
			if (have_w) r = w;
			r.kind   = RK_STATUS;
			r.status = st;
			return 1'b1;
		end
		if (have_w) begin
			r = w;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int field_diff(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		if (!arst_n) begin
			frame_bytes = FRAME_BYTES_RST;
			restart_record();
			awaited_results.delete();
			fail_n = 0;
			outstanding <= 0;
			failures    <= 0;
		end else begin
			if (cfg_we) frame_bytes = cfg_wdata;
			// results leave only after their word has passed the queue and the result register, so compare before predicting
			if (m_tvalid && m_tready) begin
				got.kind      = m_tuser;
				got.wr_offset = m_tdata[15:0];
				got.wr_length = m_tdata[29:16];
				got.wr_value  = m_tdata[37:30];
				got.status    = status_t'(m_tdata[40:38]);
				if (awaited_results.size() == 0) begin
					$error("result word with nothing expected: kind %0d offset %0d status %0d",
						got.kind, got.wr_offset, got.status);
					fail_n++;
				end else begin
					want = awaited_results.pop_front();
					fail_n += field_diff("result_kind", want.kind, got.kind);
					fail_n += field_diff("write_offset", want.wr_offset, got.wr_offset);
					fail_n += field_diff("write_length", want.wr_length, got.wr_length);
					fail_n += field_diff("write_value", want.wr_value, got.wr_value);
					fail_n += field_diff("status", want.status, got.status);
				end
			end
			if (s_tvalid && s_tready) begin
				if (decode_word(s_tuser, s_tdata, s_tlast, want)) awaited_results.push_back(want);
			end
			outstanding <= awaited_results.size();
			failures    <= fail_n;
		end
	end

endmodule

// ===== test/run_skip_dump_frame_decoder_test.sv =====
// Test top of the run/skip/dump frame decoder: builds delta records word by word,
// idles both stream sides at random and gives the verdict from the scoreboard.
// Depends on rsd_pkg, rsd_test_pkg, rsd_scoreboard and the decoder RTL.
`timescale 1ns / 1ps

module run_skip_dump_frame_decoder_test;
	import rsd_pkg::*;
	import rsd_test_pkg::*;

	localparam int WORD_GOAL   = 1700;     // record words to send before stopping
	localparam int PHASE_WORDS = 280;      // record words per frame_bytes setting
	localparam int HOLD_CYCLES = 300;      // long receiver hold-off, fills the decoder
	localparam int SETTLE      = 10;       // covers queue plus result register latency
	localparam int RUN_LIMIT   = 5000000;  // ns

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // [7:0] data_byte
	logic        s_tuser = 1'b0;   // [0] req_type
	logic        s_tlast = 1'b0;   // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // [15:0] offset, [29:16] length, [37:30] value, [40:38] status
	logic        m_tuser;          // [0] result_kind
	int          outstanding;
	int          failures;

	logic [7:0] rec[$];            // record under construction
	int         frame_sz = 64000;  // mirror of the frame_bytes register
	int         words_sent = 0;
	int         s_seg = 0;
	bit         s_calm = 1'b0;

	always #5 clk = ~clk;

	run_skip_dump_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	rsd_scoreboard scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.outstanding (outstanding),
		.failures    (failures)
	);

	// Idle cycles ahead of the next word. Work in segments: some run flat out,
	// the others draw a fresh random wait for each word.
	function automatic int draw_gap(inout int seg_left, inout bit calm);
		if (seg_left == 0) begin
			seg_left = $urandom_range(10, 60);
			calm     = ($urandom_range(0, 2) == 0);
		end
		seg_left--;
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	// Offer one word and hold it until accepted. Valid stays high straight into
	// the next word when no gap is drawn, so it is never dropped and raised in one step.
	task automatic send_word(input logic req, input logic [7:0] b, input logic last);
		int gap;
		gap = draw_gap(s_seg, s_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= req;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	// Send the built record; mark the final word as last only for a closed record.
	task automatic send_record(input bit closed);
		int i;
		for (i = 0; i < rec.size(); i++) begin
			send_word(REQ_DATA, rec[i], closed && (i == rec.size() - 1));
		end
		rec.delete();
	endtask

	// Stop offering and wait for every predicted result word to come out.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Change frame_bytes only with the decoder empty: results drained, and words
	// that give no result flushed through the queue by the settle time.
	task automatic set_frame_bytes(input logic [15:0] v);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		frame_sz  = v;
	endtask

	task automatic put_type(input logic [15:0] t);
		rec.push_back(t[7:0]);
		rec.push_back(t[15:8]);
	endtask

	task automatic put_long(input logic [15:0] w);
		rec.push_back(LONG_OP);
		rec.push_back(w[7:0]);
		rec.push_back(w[15:8]);
	endtask

	// Dump of n literal bytes; short form needs 1..127.
	task automatic put_dump(input int n, input bit long_form);
		int i;
		if (long_form || n > 127) put_long(LONG_DUMP_BASE + n);
		else rec.push_back(n);
		for (i = 0; i < n; i++) rec.push_back(8'($urandom));
	endtask

	task automatic put_run(input int n, input bit long_form);
		if (long_form || n > 255) begin
			put_long(LONG_RUN_BASE + n);
		end else begin
			rec.push_back(RUN_OP);
			rec.push_back(n);
		end
		rec.push_back(8'($urandom));
	endtask

	// Skip any distance, split into the largest long skips, with a short skip for a remainder of up to 127.
	task automatic put_skip(input int n);
		int chunk;
		while (n > 0) begin
			chunk = (n > 32767) ? 32767 : n;
			if (chunk <= 127) rec.push_back(LONG_OP + chunk);
			else put_long(chunk);
			n -= chunk;
		end
	endtask

	task automatic put_stop();
		put_long(STOP_WORD);
	endtask

	// One random record. Most are run/skip/dump records with random content, some
	// of them broken; the rest are empty requests, raw bodies, odd types, short
	// records and noise.
	task automatic send_random_record();
		int pick;
		int n;
		int k;
		int j;
		bit closed;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			send_word(REQ_EMPTY, 8'($urandom), 1'($urandom));
		end else if (pick < 12) begin
			n = $urandom_range(1, 6);
			for (k = 0; k < n; k++) rec.push_back(8'($urandom));
			send_record(1'b1);
		end else if (pick < 22) begin
			// raw body: match the frame size where that stays short
			put_type(TYPE_RAW);
			if (frame_sz <= 96 && $urandom_range(0, 3) != 0) begin
				n = frame_sz;
				if ($urandom_range(0, 4) == 0) n += $urandom_range(0, 1) ? 1 : -1;
			end else begin
				n = $urandom_range(0, 12);
			end
			for (k = 0; k < n; k++) rec.push_back(8'($urandom));
			send_record(1'b1);
		end else if (pick < 27) begin
			put_type(16'($urandom_range(2, 65535)));
			n = $urandom_range(0, 5);
			for (k = 0; k < n; k++) rec.push_back(8'($urandom));
			send_record(1'b1);
		end else if (pick < 30) begin
			// one-byte record or type-only record
			rec.push_back(8'($urandom));
			if ($urandom_range(0, 1)) rec.push_back(8'($urandom));
			send_record(1'b1);
		end else if (pick < 34) begin
			// land on the last frame byte: the first dump byte fits, the second overruns
			put_type(TYPE_RSD);
			put_skip(frame_sz - 1);
			put_dump(2, 1'b0);
			put_stop();
			send_record(1'b1);
		end else begin
			put_type(TYPE_RSD);
			n = $urandom_range(1, 6);
			for (k = 0; k < n; k++) begin
				case ($urandom_range(0, 9))
				0, 1, 2: put_dump(($urandom_range(0, 15) == 0) ? 127 : $urandom_range(1, 8), 1'b0);
				3: put_dump($urandom_range(0, 6), 1'b1);
				4, 5: put_run(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) :
					$urandom_range(1, 16), 1'b0);
				6: put_run(($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383) :
					$urandom_range(0, 40), 1'b1);
				7: put_skip($urandom_range(1, 127));
				8: put_skip(($urandom_range(0, 7) == 0) ? $urandom_range(128, 32767) :
					$urandom_range(128, 600));
				default: begin
					// early stop, then bytes that only count toward the length
					put_stop();
					for (j = $urandom_range(1, 3); j > 0; j--) rec.push_back(8'($urandom));
				end
				endcase
			end
			case ($urandom_range(0, 7))
			0: send_record(1'b1);    // no closing stop code
			1: begin
				// long op with a nonzero middle byte: a skip, not a stop code
				rec.push_back(LONG_OP);
				rec.push_back(8'($urandom_range(1, 255)));
				rec.push_back(8'h00);
				send_record(1'b1);
			end
			2: begin
				// cut short; an open record is dropped by an empty request
				put_stop();
				n = $urandom_range(1, rec.size() - 1);
				while (rec.size() > n) void'(rec.pop_back());
				closed = $urandom_range(0, 1);
				send_record(closed);
				if (!closed) send_word(REQ_EMPTY, 8'($urandom), 1'($urandom));
			end
			default: begin
				put_stop();
				send_record(1'b1);
			end
			endcase
		end
	endtask

	// Receiver: per result a random wait, and now and then a long hold-off while
	// the sender keeps offering, so the queue fills and s_tready drops.
	initial begin : receiver
		int gap;
		int seg;
		int taken;
		bit calm;
		seg   = 0;
		calm  = 1'b0;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = (taken % 500 == 50) ? HOLD_CYCLES : draw_gap(seg, calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			taken++;
		end
	end

	// Stimulus: directed records at the reset frame size, then random records
	// over a series of frame_bytes settings that include both extremes.
	initial begin : stimulus
		int ph;
		int phase_end;
		bit paused;
		logic [15:0] fb;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte record, empty request, type-only record
		rec.push_back(8'h00);
		send_record(1'b1);
		send_word(REQ_EMPTY, 8'hFF, 1'b1);
		put_type(TYPE_RSD);
		send_record(1'b1);
		// unsupported type with a body byte
		put_type(16'hFFFF);
		rec.push_back(8'h12);
		send_record(1'b1);
		// short raw body: writes, then size mismatch
		put_type(TYPE_RAW);
		rec.push_back(8'hFF);
		rec.push_back(8'h00);
		send_record(1'b1);
		// every op: dump, short skip, zero-length run, longest skip, longest run, stop
		put_type(TYPE_RSD);
		put_dump(1, 1'b0);
		put_skip(127);
		put_run(0, 1'b0);
		put_skip(32767);
		put_run(16383, 1'b1);
		put_stop();
		send_record(1'b1);

		for (ph = 0; words_sent < WORD_GOAL; ph++) begin
			case (ph % 6)
			0: fb = 16'hFFFF;
			1: fb = 16'd1;
			2: fb = $urandom_range(2, 64);
			3: fb = $urandom_range(65, 160);
			4: fb = $urandom_range(1, 65535);
			default: fb = $urandom_range(8, 24);
			endcase
			set_frame_bytes(fb);
			phase_end = words_sent + PHASE_WORDS;
			paused = 1'b0;
			while (words_sent < phase_end) begin
				// halfway through, let the output side empty completely
				if (!paused && words_sent > phase_end - PHASE_WORDS / 2) begin
					drain_results();
					paused = 1'b1;
				end
				send_random_record();
			end
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (failures == 0 && outstanding == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
